/* hdl/cda_pkg.sv */
package cda_pkg;

  // Field widths of the date and the day count.
  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 16;

  // Operation codes carried in the mode field.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_ADD  = 1'b1;

  // Date that reset and a rejected load leave behind.
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 16'd1970;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;

  // Month codes that matter for month length and rollover.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAYS_LEAP_FEB = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;

  // Length of a month. Every year divisible by four is a leap year, with no
  // century rule, so only the two low bits of the year are needed.
  function automatic logic [DAY_W-1:0] month_length(input logic [1:0] yr_lo,
                                                     input logic [MONTH_W-1:0] mo);
    logic [DAY_W-1:0] len;
    unique case (mo) inside
      MONTH_FEB: len = (yr_lo == 2'b00) ? DAYS_LEAP_FEB : DAYS_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
      default: len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

/* hdl/cda_if.sv */
// Request channel into the block: one load or add operation.
interface cda_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [cda_pkg::YEAR_W-1:0]    year;
  logic [cda_pkg::MONTH_W-1:0]   month;
  logic [cda_pkg::DAY_W-1:0]     day;
  logic [cda_pkg::COUNT_W-1:0]   day_count;

  modport source (output valid, output mode, output year, output month,
                  output day, output day_count, input ready);
  modport sink   (input valid, input mode, input year, input month,
                  input day, input day_count, output ready);
endinterface

// Result channel out of the block: the stored date and status flags.
interface cda_out_if;
  logic                          valid;
  logic                          ready;
  logic [cda_pkg::YEAR_W-1:0]    cur_year;
  logic [cda_pkg::MONTH_W-1:0]   cur_month;
  logic [cda_pkg::DAY_W-1:0]     cur_day;
  logic                          load_rejected;
  logic                          year_wrapped;

  modport source (output valid, output cur_year, output cur_month, output cur_day,
                  output load_rejected, output year_wrapped, input ready);
  modport sink   (input valid, input cur_year, input cur_month, input cur_day,
                  input load_rejected, input year_wrapped, output ready);
endinterface

/* hdl/calendar_date_add_days.sv */
// A load request, or an add of zero days, shows its result in the cycle after acceptance.
// An add of N > 0 days walks the date in ST_ADD, one month per cycle, through the day adder and
// compare of the step unit, and shows its result once the rest of the count fits in the month.
// One request is in work at a time.
// Handshake: the next request is accepted at the same edge at which the result is taken.
// Reset (synchronous, rst_n low) sets the date to 1970-01-01 and empties the result register.
module calendar_date_add_days (
  input  logic            clk,
  input  logic            rst_n,
  cda_in_if.sink          in_ch,
  cda_out_if.source       out_ch
);

  typedef enum logic {
    ST_IDLE,
    ST_ADD
  } state_t;

  localparam logic [cda_pkg::YEAR_W-1:0] YEAR_MAX = '1;

  state_t                        state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [cda_pkg::YEAR_W-1:0]    year_r, year_nxt;
  logic [cda_pkg::MONTH_W-1:0]   month_r, month_nxt;
  logic [cda_pkg::DAY_W-1:0]     day_r, day_nxt;
  logic [cda_pkg::COUNT_W-1:0]   left_r, left_nxt;
  logic                          rej_r, rej_nxt;
  logic                          wrap_r, wrap_nxt;

  logic                          in_accept;
  logic                          load_ok;
  logic [cda_pkg::DAY_W-1:0]     load_len;
  logic [cda_pkg::DAY_W-1:0]     cur_len;
  logic [cda_pkg::COUNT_W:0]     day_sum;
  logic                          step_over;
  logic [cda_pkg::COUNT_W-1:0]   left_step;

  // A new request is taken when idle and the result register is free or draining.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Validity check for a load request.
  assign load_len = cda_pkg::month_length(in_ch.year[1:0], in_ch.month);
  assign load_ok  = (in_ch.month >= cda_pkg::MONTH_JAN) && (in_ch.month <= cda_pkg::MONTH_DEC)
                    && (in_ch.day != '0) && (in_ch.day <= load_len);

  // Step unit: day add and compare against the current month length, and the count left after a month step.
  assign cur_len   = cda_pkg::month_length(year_r[1:0], month_r);
  assign day_sum   = {{(cda_pkg::COUNT_W + 1 - cda_pkg::DAY_W){1'b0}}, day_r}
                     + {1'b0, left_r};
  assign step_over = day_sum > {{(cda_pkg::COUNT_W + 1 - cda_pkg::DAY_W){1'b0}}, cur_len};
  assign left_step = left_r - cda_pkg::COUNT_W'(cur_len) + cda_pkg::COUNT_W'(day_r)
                     - cda_pkg::COUNT_W'(1);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    left_nxt      = left_r;
    rej_nxt       = rej_r;
    wrap_nxt      = wrap_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          rej_nxt  = 1'b0;
          wrap_nxt = 1'b0;
          if (in_ch.mode == cda_pkg::MODE_LOAD) begin
            out_valid_nxt = 1'b1;
            if (load_ok) begin
              year_nxt  = in_ch.year;
              month_nxt = in_ch.month;
              day_nxt   = in_ch.day;
            end else begin
              year_nxt  = cda_pkg::RESET_YEAR;
              month_nxt = cda_pkg::RESET_MONTH;
              day_nxt   = cda_pkg::RESET_DAY;
              rej_nxt   = 1'b1;
            end
          end else begin
            left_nxt = in_ch.day_count;
            if (in_ch.day_count == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = ST_ADD;
            end
          end
        end
      end
      ST_ADD: begin
        if (step_over) begin
          // Move to the first day of the next month.
          left_nxt = left_step;
          day_nxt  = cda_pkg::RESET_DAY;
          if (month_r >= cda_pkg::MONTH_DEC) begin
            month_nxt = cda_pkg::MONTH_JAN;
            if (year_r == YEAR_MAX) begin
              year_nxt = '0;
              wrap_nxt = 1'b1;
            end else begin
              year_nxt = year_r + cda_pkg::YEAR_W'(1);
            end
          end else begin
            month_nxt = month_r + cda_pkg::MONTH_W'(1);
          end
        end else begin
          // The rest of the count fits inside this month.
          day_nxt       = day_sum[cda_pkg::DAY_W-1:0];
          left_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      year_r      <= cda_pkg::RESET_YEAR;
      month_r     <= cda_pkg::RESET_MONTH;
      day_r       <= cda_pkg::RESET_DAY;
      rej_r       <= 1'b0;
      wrap_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      rej_r       <= rej_nxt;
      wrap_r      <= wrap_nxt;
    end
    left_r <= left_nxt;
  end

  // The result register holds the stored date and the flags of the last request.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.cur_year      = year_r;
  assign out_ch.cur_month     = month_r;
  assign out_ch.cur_day       = day_r;
  assign out_ch.load_rejected = rej_r;
  assign out_ch.year_wrapped  = wrap_r;

  // A load request produces its result in the next cycle.
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_ch.mode == cda_pkg::MODE_LOAD) |=> out_valid_r)
    else $error("load request did not produce a result");

  // No result is shown and no request is taken while an add is still walking the date.
  a_no_result_in_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |-> !out_valid_r && !in_ch.ready)
    else $error("result or request handshake open during add");

  // A stalled result stays valid and keeps the stored date unchanged.
  a_stall_holds_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(year_r) && $stable(month_r)
                                     && $stable(day_r))
    else $error("stored date changed under a stalled result");

  // A rejected load always leaves the reset date.
  a_reject_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rej_r |-> (year_r == cda_pkg::RESET_YEAR)
                             && (month_r == cda_pkg::RESET_MONTH)
                             && (day_r == cda_pkg::RESET_DAY) && !wrap_r)
    else $error("rejected load left a date other than the reset date");

  // While a result is shown, the stored date is a legal calendar date.
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (month_r >= cda_pkg::MONTH_JAN) && (month_r <= cda_pkg::MONTH_DEC)
                    && (day_r != '0) && (day_r <= cur_len))
    else $error("stored date is not a legal date");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  // One request as driven on the input channel.
  typedef struct packed {
    logic                        mode;
    logic [cda_pkg::YEAR_W-1:0]  year;
    logic [cda_pkg::MONTH_W-1:0] month;
    logic [cda_pkg::DAY_W-1:0]   day;
    logic [cda_pkg::COUNT_W-1:0] day_count;
  } date_req_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [cda_pkg::YEAR_W-1:0]  year;
    logic [cda_pkg::MONTH_W-1:0] month;
    logic [cda_pkg::DAY_W-1:0]   day;
    logic                        rejected;
    logic                        wrapped;
  } date_res_t;

  // Worst run is a few hundred full-length adds; this allows several times that.
  localparam longint RUN_LIMIT_NS = 64'd15_000_000;

  logic clk;
  logic rst_n;
  bit   calm;
  int   n_errors;

  // Date that the block should be holding, and the results still owed.
  logic [cda_pkg::YEAR_W-1:0]  cal_year;
  logic [cda_pkg::MONTH_W-1:0] cal_month;
  logic [cda_pkg::DAY_W-1:0]   cal_day;
  date_res_t                   date_expect_q[$];

  cda_in_if  in_ch();
  cda_out_if out_ch();

  calendar_date_add_days i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock, 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Month length with the plain divisible-by-four leap rule.
  function automatic logic [cda_pkg::DAY_W-1:0] days_in_month(
      input logic [cda_pkg::YEAR_W-1:0] yr, input logic [cda_pkg::MONTH_W-1:0] mo);
    if (mo == cda_pkg::MONTH_FEB) begin
      return (yr[1:0] == 2'b00) ? cda_pkg::DAYS_LEAP_FEB : cda_pkg::DAYS_FEB;
    end
    if (mo == cda_pkg::MONTH_APR || mo == cda_pkg::MONTH_JUN || mo == cda_pkg::MONTH_SEP ||
        mo == cda_pkg::MONTH_NOV) begin
      return cda_pkg::DAYS_SHORT;
    end
    return cda_pkg::DAYS_LONG;
  endfunction

  // Applies one request to the tracked date and returns the result it must produce.
  function automatic date_res_t predict_date(input date_req_t req);
    date_res_t                 res;
    int unsigned               left;
    logic [cda_pkg::DAY_W-1:0] len;
    res = '0;
    if (req.mode == cda_pkg::MODE_LOAD) begin
      if (req.month >= cda_pkg::MONTH_JAN && req.month <= cda_pkg::MONTH_DEC &&
          req.day != '0 && req.day <= days_in_month(req.year, req.month)) begin
        cal_year  = req.year;
        cal_month = req.month;
        cal_day   = req.day;
      end else begin
        cal_year     = cda_pkg::RESET_YEAR;
        cal_month    = cda_pkg::RESET_MONTH;
        cal_day      = cda_pkg::RESET_DAY;
        res.rejected = 1'b1;
      end
    end else begin
      left = 32'(req.day_count);
      // Walk forward one month at a time until the remaining days fit.
      while (left > 0) begin
        len = days_in_month(cal_year, cal_month);
        if (32'(cal_day) + left > 32'(len)) begin
          left    = left - ((32'(len) - 32'(cal_day)) + 32'd1);
          cal_day = cda_pkg::RESET_DAY;
          if (cal_month >= cda_pkg::MONTH_DEC) begin
            cal_month = cda_pkg::MONTH_JAN;
            if (cal_year == '1) begin
              res.wrapped = 1'b1;
            end
            cal_year = cal_year + cda_pkg::YEAR_W'(1);
          end else begin
            cal_month = cal_month + cda_pkg::MONTH_W'(1);
          end
        end else begin
          cal_day = cal_day + left[cda_pkg::DAY_W-1:0];
          left    = 0;
        end
      end
    end
    res.year  = cal_year;
    res.month = cal_month;
    res.day   = cal_day;
    return res;
  endfunction

  // Load request; the unused count field still carries random bits.
  function automatic date_req_t load_req(input int unsigned yr, input int unsigned mo,
                                         input int unsigned dy);
    date_req_t req;
    req.mode      = cda_pkg::MODE_LOAD;
    req.year      = cda_pkg::YEAR_W'(yr);
    req.month     = cda_pkg::MONTH_W'(mo);
    req.day       = cda_pkg::DAY_W'(dy);
    req.day_count = cda_pkg::COUNT_W'($urandom_range(16'hFFFF));
    return req;
  endfunction

  // Add request; the unused date fields still carry random bits.
  function automatic date_req_t add_req(input int unsigned cnt);
    date_req_t req;
    req.mode      = cda_pkg::MODE_ADD;
    req.year      = cda_pkg::YEAR_W'($urandom_range(16'hFFFF));
    req.month     = cda_pkg::MONTH_W'($urandom_range(15));
    req.day       = cda_pkg::DAY_W'($urandom_range(31));
    req.day_count = cda_pkg::COUNT_W'(cnt);
    return req;
  endfunction

  // Sends one request, with an occasional gap ahead of it, and records its result.
  task automatic send_date_req(input date_req_t req);
    if (!calm && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= req.mode;
    in_ch.year      <= req.year;
    in_ch.month     <= req.month;
    in_ch.day       <= req.day;
    in_ch.day_count <= req.day_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    date_expect_q.push_back(predict_date(req));
  endtask

  // Holds the input idle until every owed result has come back.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (date_expect_q.size() != 0) @(posedge clk);
  endtask

  // Result consumer: random stalls except during calm stretches.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 33);
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    date_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (date_expect_q.size() == 0) begin
        $error("unexpected result: %0d-%0d-%0d", out_ch.cur_year, out_ch.cur_month,
               out_ch.cur_day);
        n_errors++;
      end else begin
        want = date_expect_q.pop_front();
        if (out_ch.cur_year !== want.year) begin
          $error("cur_year: expected %0d, got %0d", want.year, out_ch.cur_year);
          n_errors++;
        end
        if (out_ch.cur_month !== want.month) begin
          $error("cur_month: expected %0d, got %0d", want.month, out_ch.cur_month);
          n_errors++;
        end
        if (out_ch.cur_day !== want.day) begin
          $error("cur_day: expected %0d, got %0d", want.day, out_ch.cur_day);
          n_errors++;
        end
        if (out_ch.load_rejected !== want.rejected) begin
          $error("load_rejected: expected %0d, got %0d", want.rejected,
                 out_ch.load_rejected);
          n_errors++;
        end
        if (out_ch.year_wrapped !== want.wrapped) begin
          $error("year_wrapped: expected %0d, got %0d", want.wrapped, out_ch.year_wrapped);
          n_errors++;
        end
      end
    end
  end

  // Valid and invalid loads at the edges of every field.
  task automatic test_load_checks();
    send_date_req(load_req(2024, 2, 29));
    send_date_req(load_req(2023, 2, 29));
    send_date_req(load_req(0, 2, 29));
    send_date_req(load_req(1900, 2, 29));
    send_date_req(load_req(2023, 2, 28));
    send_date_req(load_req(16'hFFFF, 12, 31));
    send_date_req(load_req(2000, 0, 10));
    send_date_req(load_req(2000, 13, 10));
    send_date_req(load_req(16'hFFFF, 15, 31));
    send_date_req(load_req(2000, 5, 0));
    send_date_req(load_req(2000, 4, 31));
    send_date_req(load_req(2000, 4, 30));
    send_date_req(load_req(2000, 11, 31));
    send_date_req(load_req(0, 1, 31));
  endtask

  // Zero count, year rollover, leap February and the year wrap.
  task automatic test_add_edges();
    send_date_req(add_req(0));
    send_date_req(load_req(1999, 12, 31));
    send_date_req(add_req(1));
    send_date_req(load_req(2024, 2, 28));
    send_date_req(add_req(1));
    send_date_req(add_req(30));
    send_date_req(load_req(16'hFFFF, 12, 31));
    send_date_req(add_req(1));
    send_date_req(load_req(16'hFFFF, 1, 1));
    send_date_req(add_req(16'hFFFF));
  endtask

  // A few requests, then the sender holds off until the block has gone quiet.
  task automatic test_drain_pause();
    send_date_req(load_req(2012, 6, 15));
    send_date_req(add_req(400));
    wait_results_drained();
    send_date_req(add_req(45));
    send_date_req(load_req(3, 2, 29));
    wait_results_drained();
  endtask

  // Day counts weighted toward short adds, with some full-range ones.
  function automatic int unsigned rand_day_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4)  return 0;
    if (pick < 8)  return 16'hFFFF;
    if (pick < 75) return $urandom_range(1, 400);
    if (pick < 92) return $urandom_range(401, 5000);
    return $urandom_range(16'hFFFF);
  endfunction

  // Mostly a valid load followed by a few adds; the rest is arbitrary field noise.
  task automatic test_random_sequences(input int n_reqs);
    int          sent;
    int unsigned yr;
    int unsigned mo;
    while (sent < n_reqs) begin
      // Long stretch with neither side idling.
      calm = (sent >= n_reqs / 3 && sent < n_reqs / 3 + 60);
      if ($urandom_range(99) < 80) begin
        yr = ($urandom_range(3) == 0) ? 16'hFFFF - $urandom_range(200)
                                      : $urandom_range(16'hFFFF);
        mo = $urandom_range(1, 12);
        send_date_req(load_req(yr, mo, $urandom_range(1, days_in_month(
            cda_pkg::YEAR_W'(yr), cda_pkg::MONTH_W'(mo)))));
        sent++;
        repeat ($urandom_range(1, 4)) begin
          send_date_req(add_req(rand_day_count()));
          sent++;
        end
      end else begin
        send_date_req(load_req($urandom_range(16'hFFFF), $urandom_range(15),
                               $urandom_range(31)));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    rst_n           = 1'b0;
    calm            = 1'b0;
    n_errors        = 0;
    cal_year        = cda_pkg::RESET_YEAR;
    cal_month       = cda_pkg::RESET_MONTH;
    cal_day         = cda_pkg::RESET_DAY;
    in_ch.valid     = 1'b0;
    in_ch.mode      = cda_pkg::MODE_LOAD;
    in_ch.year      = '0;
    in_ch.month     = '0;
    in_ch.day       = '0;
    in_ch.day_count = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_checks();
    test_add_edges();
    test_drain_pause();
    test_random_sequences(220);

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
